>>> src/deq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue.
// No dependencies; used by every module of the block through scoped names.
package deq_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Port field widths
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SHOW       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic                load;        // latch request, clear show offset
    logic                push;        // write ring, move pointers
    logic                read;        // issue ring read
    logic                pop;         // commit a pop
    logic                show_inc;    // advance show offset
    logic                emit;        // load output register
    logic [STATUS_W-1:0] emit_status;
    logic                emit_rd;     // word comes from read data
    logic                emit_last;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              full;
    logic              out_free;
    logic              show_last;
  } stat_t;

  // (a + b) mod DEPTH for a, b < DEPTH
  function automatic idx_t wrap_add(idx_t a, idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // (a - 1) mod DEPTH
  function automatic idx_t wrap_dec(idx_t a);
    idx_t r;
    if (a == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = a - 1'b1;
    end
    return r;
  endfunction

endpackage

>>> src/deq_datapath.sv
// Datapath of the double-ended queue: ring memory, front pointer, count,
// show offset and the output register. Depends on deq_pkg.
module deq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [deq_pkg::FUNC_W-1:0]    func_i,
  input  logic signed [deq_pkg::VALUE_W-1:0] value_i,
  input  deq_pkg::cmd_t                 cmd_i,
  output deq_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [deq_pkg::STATUS_W-1:0]  status_o,
  output logic signed [deq_pkg::VALUE_W-1:0] word_o,
  output logic [deq_pkg::FILL_W-1:0]    fill_o,
  output logic                          last_o
);

  // Ring storage
  deq_pkg::data_t mem [deq_pkg::DEPTH];
  deq_pkg::data_t rd_data_q;

  // Request and pointer registers
  logic [deq_pkg::FUNC_W-1:0] func_q;
  deq_pkg::data_t             value_q;
  deq_pkg::idx_t              front_q, front_d;
  deq_pkg::cnt_t              count_q, count_d;
  deq_pkg::idx_t              show_q;

  // Output register
  logic                          out_valid_q;
  logic [deq_pkg::STATUS_W-1:0]  status_q;
  deq_pkg::data_t                word_q;
  deq_pkg::cnt_t                 fill_q;
  logic                          last_q;

  deq_pkg::idx_t wr_addr;
  deq_pkg::idx_t rd_addr;
  deq_pkg::idx_t last_off;
  logic          out_free;

  assign last_off = deq_pkg::IDX_W'(count_q - 1'b1);
  assign out_free = !out_valid_q || !out_stall_i;

  // Status to the controller
  assign stat_o.func      = func_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign stat_o.out_free  = out_free;
  assign stat_o.show_last = (deq_pkg::CNT_W'(show_q) + 1'b1 == count_q);

  // Address selection
  always_comb begin
    if (func_q == deq_pkg::FUNC_PUSH_FRONT) begin
      wr_addr = deq_pkg::wrap_dec(front_q);
    end else begin
      wr_addr = deq_pkg::wrap_add(front_q, deq_pkg::IDX_W'(count_q));
    end
    case (func_q)
      deq_pkg::FUNC_POP_FRONT: rd_addr = front_q;
      deq_pkg::FUNC_POP_BACK:  rd_addr = deq_pkg::wrap_add(front_q, last_off);
      default:                 rd_addr = deq_pkg::wrap_add(front_q, show_q);
    endcase
  end

  // Pointer and count update
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.push) begin
      if (func_q == deq_pkg::FUNC_PUSH_FRONT) begin
        front_d = wr_addr;
      end
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      if (func_q == deq_pkg::FUNC_POP_FRONT) begin
        front_d = deq_pkg::wrap_add(front_q, deq_pkg::IDX_W'(1));
      end
      count_d = count_q - 1'b1;
    end
  end

  // Ring write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= value_q;
    end
    if (cmd_i.read) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Request latch (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= deq_pkg::DATA_WIDTH'(value_i);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      show_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.load) begin
        show_q <= '0;
      end else if (cmd_i.show_inc) begin
        show_q <= show_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      word_q   <= cmd_i.emit_rd ? rd_data_q : '0;
      fill_q   <= count_d;
      last_q   <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign word_o      = deq_pkg::VALUE_W'(word_q);
  assign fill_o      = deq_pkg::FILL_W'(fill_q);
  assign last_o      = last_q;

endmodule

>>> src/deq_ctrl.sv
// Controller state machine of the double-ended queue.
// Sequences accept, read, commit and emit; depends on deq_pkg.
module deq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  deq_pkg::stat_t stat_i,
  output deq_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_EXEC      = 3'd1;
  localparam logic [2:0] ST_POP_EMIT  = 3'd2;
  localparam logic [2:0] ST_SHOW_RD   = 3'd3;
  localparam logic [2:0] ST_SHOW_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat_i.func)
          deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
            if (stat_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.emit_status = deq_pkg::STATUS_FULL;
              end else begin
                cmd_o.push        = 1'b1;
                cmd_o.emit_status = deq_pkg::STATUS_OK;
              end
              state_d = ST_IDLE;
            end
          end
          deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_SHOW: begin
            if (stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_last   = 1'b1;
                cmd_o.emit_status = deq_pkg::STATUS_EMPTY;
                state_d           = ST_IDLE;
              end
            end else begin
              cmd_o.read = 1'b1;
              state_d    = (stat_i.func == deq_pkg::FUNC_SHOW) ? ST_SHOW_EMIT : ST_POP_EMIT;
            end
          end
          default: begin
            // unknown function: dropped
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_POP_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.pop         = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_rd     = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = deq_pkg::STATUS_OK;
          state_d           = ST_IDLE;
        end
      end
      ST_SHOW_RD: begin
        cmd_o.read = 1'b1;
        state_d    = ST_SHOW_EMIT;
      end
      ST_SHOW_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_rd     = 1'b1;
          cmd_o.emit_last   = stat_i.show_last;
          cmd_o.emit_status = deq_pkg::STATUS_OK;
          if (stat_i.show_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.show_inc = 1'b1;
            state_d        = ST_SHOW_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/double_ended_queue_top.sv
// Double-ended queue of signed words held in a ring of deq_pkg::DEPTH entries.
// Usage:
//   Input channel (in_valid_i / in_stall_o, func_i, value_i) takes one request:
//   push front, pop front, push back, pop back or show all. Other codes are
//   dropped without a result.
//   Output channel (out_valid_o / out_stall_i, status_o, word_o, fill_o,
//   last_o) returns results; last_o marks the final result of a request.
// Sequencing:
//   A request is taken only when the controller is idle. A push, a refused
//   push or an empty pop/show loads its result in the execute state; a pop
//   issues the registered ring read there and loads its result in the
//   pop-emit state. Show reads, then emits, each stored word in turn. The next
//   request is taken the cycle after the last result is loaded.
// Reset clears the front pointer, count, state and output valid; the ring
// contents are undefined until written.
// A stalled receiver holds the output register; the controller waits with
// the next result until it is taken, and does not take new requests meanwhile.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
module double_ended_queue_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [deq_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [deq_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [deq_pkg::STATUS_W-1:0]       status_o,
  output logic signed [deq_pkg::VALUE_W-1:0] word_o,
  output logic [deq_pkg::FILL_W-1:0]         fill_o,
  output logic                               last_o
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  deq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (func_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .word_o      (word_o),
    .fill_o      (fill_o),
    .last_o      (last_o)
  );

endmodule

>>> src/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg.
module deq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [deq_pkg::FUNC_W-1:0]         func_i,
  input logic signed [deq_pkg::VALUE_W-1:0] value_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [deq_pkg::STATUS_W-1:0]       status_o,
  input logic signed [deq_pkg::VALUE_W-1:0] word_o,
  input logic [deq_pkg::FILL_W-1:0]         fill_o,
  input logic                               last_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(word_o)
      && $stable(fill_o) && $stable(last_o))
    else $error("stalled result changed");

  // One request at a time: stall rises after each accepted request
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // Refused push only on a full queue
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == deq_pkg::STATUS_FULL |->
      fill_o == deq_pkg::FILL_W'(deq_pkg::DEPTH) && last_o)
    else $error("full status with wrong fill");

  // Empty results carry no word and no fill
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == deq_pkg::STATUS_EMPTY |->
      fill_o == '0 && word_o == '0 && last_o)
    else $error("empty status with data");

  // Only show results can be non-final, and they are ok
  a_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == deq_pkg::STATUS_OK && fill_o != '0)
    else $error("bad non-final result");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .func_i      (func_i),
  .value_i     (value_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .word_o      (word_o),
  .fill_o      (fill_o),
  .last_o      (last_o)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// Testbench for double_ended_queue_top: directed table, then random requests
// checked against a behavioral predictor of the ring. Needs deq_pkg and the RTL.
module testbench;
  import deq_pkg::*;

  // Function codes outside the defined set; the block drops them silently
  localparam logic [FUNC_W-1:0] FUNC_BAD_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_BAD_HI = 3'd7;

  localparam int RANDOM_REQUESTS  = 180;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES    = 20;
  localparam int REPORT_LIMIT     = 10;
  localparam int TIMEOUT_NS       = 5_000_000;
  localparam int PLAN_ROWS        = 16;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  word;
    logic [FILL_W-1:0]   fill;
    logic                last;
  } deq_result_t;

  // One row of directed stimulus; typed rows carry their own single result
  typedef struct packed {
    logic [FUNC_W-1:0]   op;
    logic [VALUE_W-1:0]  value;
    bit                  rand_value;
    logic [4:0]          rep;
    bit                  typed;
    logic [STATUS_W-1:0] st;
    logic [VALUE_W-1:0]  word;
    logic [FILL_W-1:0]   fill;
  } plan_row_t;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{FUNC_POP_FRONT,  32'h0000_0000, 1'b0, 5'd1,  1'b1, STATUS_EMPTY, 32'h0, 5'd0},
    '{FUNC_POP_BACK,   32'h0000_0000, 1'b0, 5'd1,  1'b1, STATUS_EMPTY, 32'h0, 5'd0},
    '{FUNC_SHOW,       32'h0000_0000, 1'b0, 5'd1,  1'b1, STATUS_EMPTY, 32'h0, 5'd0},
    '{FUNC_BAD_LO,     32'h0000_0000, 1'b0, 5'd1,  1'b0, STATUS_OK,    32'h0, 5'd0},
    '{FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, 5'd1,  1'b1, STATUS_OK,    32'h0, 5'd1},
    '{FUNC_PUSH_BACK,  32'h8000_0000, 1'b0, 5'd1,  1'b1, STATUS_OK,    32'h0, 5'd2},
    '{FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, 5'd1,  1'b1, STATUS_OK,    32'h0, 5'd3},
    '{FUNC_PUSH_BACK,  32'h0000_0000, 1'b1, 5'd12, 1'b0, STATUS_OK,    32'h0, 5'd0},
    '{FUNC_PUSH_FRONT, 32'h0000_0000, 1'b0, 5'd1,  1'b1, STATUS_OK,    32'h0, 5'd16},
    '{FUNC_PUSH_BACK,  32'h5555_5555, 1'b0, 5'd1,  1'b1, STATUS_FULL,  32'h0, 5'd16},
    '{FUNC_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, 5'd1,  1'b1, STATUS_FULL,  32'h0, 5'd16},
    '{FUNC_SHOW,       32'h0000_0000, 1'b0, 5'd1,  1'b0, STATUS_OK,    32'h0, 5'd0},
    '{FUNC_BAD_HI,     32'h0000_0000, 1'b0, 5'd1,  1'b0, STATUS_OK,    32'h0, 5'd0},
    '{FUNC_POP_BACK,   32'h0000_0000, 1'b0, 5'd1,  1'b0, STATUS_OK,    32'h0, 5'd0},
    '{FUNC_POP_FRONT,  32'h0000_0000, 1'b0, 5'd1,  1'b1, STATUS_OK,    32'h0, 5'd14},
    '{FUNC_SHOW,       32'h0000_0000, 1'b0, 5'd1,  1'b0, STATUS_OK,    32'h0, 5'd0}
  };

  logic [VALUE_W-1:0] corner_words [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                           32'h7FFF_FFFF, 32'h8000_0000};

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [FUNC_W-1:0]          func_i;
  logic signed [VALUE_W-1:0]  value_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [STATUS_W-1:0]        status_o;
  logic signed [VALUE_W-1:0]  word_o;
  logic [FILL_W-1:0]          fill_o;
  logic                       last_o;

  // Predictor state: shadow of the ring, front slot and word count
  data_t held_ring [DEPTH];
  idx_t  head_slot  = '0;
  cnt_t  held_words = '0;

  deq_result_t awaited_results [$];
  deq_result_t oldest_result;

  int  mismatch_count  = 0;
  int  checked_results = 0;
  int  request_count   = 0;
  int  show_count      = 0;
  int  full_refusals   = 0;
  int  empty_reports   = 0;
  int  peak_fill       = 0;
  int  burst_left      = 0;
  bit  long_hold_go    = 1'b0;

  double_ended_queue_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .word_o      (word_o),
    .fill_o      (fill_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int ring_slot(input int offset);
    return (int'(head_slot) + offset) % DEPTH;
  endfunction

  function automatic void queue_result(input logic [STATUS_W-1:0] status, input data_t word,
                                       input cnt_t fill, input logic last);
    deq_result_t r;
    r = '{status, VALUE_W'(word), FILL_W'(fill), last};
    awaited_results.push_back(r);
  endfunction

  // Apply one request to the shadow ring and queue the results it should cause
  task automatic predict_deque_op(input logic [FUNC_W-1:0] op,
                                  input logic [VALUE_W-1:0] value);
    data_t popped;
    case (op)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (held_words == cnt_t'(DEPTH)) begin
          full_refusals++;
          queue_result(STATUS_FULL, '0, held_words, 1'b1);
        end else begin
          if (op == FUNC_PUSH_FRONT) begin
            head_slot = (head_slot == '0) ? idx_t'(DEPTH - 1) : head_slot - 1'b1;
            held_ring[head_slot] = data_t'(value);
          end else begin
            held_ring[ring_slot(int'(held_words))] = data_t'(value);
          end
          held_words++;
          if (int'(held_words) > peak_fill) peak_fill = int'(held_words);
          queue_result(STATUS_OK, '0, held_words, 1'b1);
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (held_words == '0) begin
          empty_reports++;
          queue_result(STATUS_EMPTY, '0, '0, 1'b1);
        end else begin
          if (op == FUNC_POP_FRONT) begin
            popped = held_ring[head_slot];
            head_slot = idx_t'(ring_slot(1));
          end else begin
            popped = held_ring[ring_slot(int'(held_words) - 1)];
          end
          held_words--;
          queue_result(STATUS_OK, popped, held_words, 1'b1);
        end
      end
      FUNC_SHOW: begin
        show_count++;
        if (held_words == '0) begin
          empty_reports++;
          queue_result(STATUS_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int k = 0; k < int'(held_words); k++) begin
            queue_result(STATUS_OK, held_ring[ring_slot(k)], held_words,
                         k == int'(held_words) - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Sender works in bursts; a gap of random length follows each burst
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end else begin
      burst_left--;
    end
  endtask

  // Offer one request, hold it until taken, then predict its results
  task automatic issue_request(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] value,
                               input bit typed, input deq_result_t typed_res);
    in_valid_i <= 1'b1;
    func_i     <= op;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    request_count++;
    predict_deque_op(op, value);
    if (typed) awaited_results[awaited_results.size() - 1] = typed_res;
    pace_sender();
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Result checker: every accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected result, status %0d word %h fill %0d last %0b",
                   $time, status_o, word_o, fill_o, last_o);
      end else begin
        oldest_result = awaited_results.pop_front();
        check_field("status", VALUE_W'(oldest_result.status), VALUE_W'(status_o));
        check_field("word",   oldest_result.word,             word_o);
        check_field("fill",   VALUE_W'(oldest_result.fill),   VALUE_W'(fill_o));
        check_field("last",   VALUE_W'(oldest_result.last),   VALUE_W'(last_o));
        checked_results++;
      end
    end
  end

  // Receiver stall pattern, plus one long hold-off when asked for
  initial begin : receiver
    int mode;
    int span;
    out_stall_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_go) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_go = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 30);
        for (int c = 0; c < span; c++) begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= 1'($urandom_range(0, 1));
            2:       out_stall_i <= c[0];
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus: directed table, then random requests
  initial begin : stimulus
    int real_items;
    int push_pct;
    int pick;
    bit hold_requested;
    bit drain_done;
    logic [FUNC_W-1:0]  op;
    logic [VALUE_W-1:0] value;
    deq_result_t        typed_res;
    real_items     = 0;
    push_pct       = 50;
    hold_requested = 1'b0;
    drain_done     = 1'b0;
    typed_res      = '0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_PUSH_FRONT;
    value_i        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[r]) begin
      for (int n = 0; n < int'(directed_plan[r].rep); n++) begin
        value = directed_plan[r].rand_value ? $urandom : directed_plan[r].value;
        typed_res = '{directed_plan[r].st, directed_plan[r].word, directed_plan[r].fill, 1'b1};
        issue_request(directed_plan[r].op, value, directed_plan[r].typed, typed_res);
      end
    end

    while (real_items < RANDOM_REQUESTS) begin
      // swing between filling, draining and balanced stretches
      if (real_items % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      if (real_items == 40 && !hold_requested) begin
        hold_requested = 1'b1;
        long_hold_go   = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3)
        op = FUNC_W'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
      else if (pick < 9)
        op = FUNC_SHOW;
      else if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      else
        op = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      value = ($urandom_range(0, 7) == 0) ? corner_words[$urandom_range(0, 3)] : $urandom;
      issue_request(op, value, 1'b0, typed_res);
      if (op <= FUNC_SHOW) real_items++;
      // one pause with the queue of results fully drained
      if (real_items == 140 && !drain_done) begin
        drain_done = 1'b1;
        in_valid_i <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests: %0d shows, %0d refused pushes, %0d empty reports",
             request_count, show_count, full_refusals, empty_reports);
    $display("%0d results checked, peak fill %0d of %0d, %0d mismatches",
             checked_results, peak_fill, DEPTH, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
